### rtl/core/sha256_pkg.sv
// ----------------------------------------------------------------------------
// sha256_pkg: shared constants and functions for the SHA-256 hasher
// Round constants, initial hash values and the sigma functions.
// ----------------------------------------------------------------------------
`default_nettype none
package sha256_pkg;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  typedef logic [31:0] word_t;

  function automatic word_t init_h(input logic [2:0] idx);
    word_t r;
    case (idx)
      3'd0: r = 32'h6a09e667;
      3'd1: r = 32'hbb67ae85;
      3'd2: r = 32'h3c6ef372;
      3'd3: r = 32'ha54ff53a;
      3'd4: r = 32'h510e527f;
      3'd5: r = 32'h9b05688c;
      3'd6: r = 32'h1f83d9ab;
      default: r = 32'h5be0cd19;
    endcase
    return r;
  endfunction

  localparam logic [31:0] ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    return (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t bsig0(input word_t x);
    return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction
  function automatic word_t bsig1(input word_t x);
    return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction
  function automatic word_t ssig0(input word_t x);
    return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction
  function automatic word_t ssig1(input word_t x);
    return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage
`default_nettype wire

### rtl/core/sha256_ifs.sv
// ----------------------------------------------------------------------------
// sha256_ifs: stream interfaces of the SHA-256 hasher
// Byte input channel and digest word output channel.
// ----------------------------------------------------------------------------
`default_nettype none
interface sha256_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last_byte;
  modport source (output valid, data_byte, byte_valid, last_byte, input ready);
  modport sink (input valid, data_byte, byte_valid, last_byte, output ready);
endinterface

interface sha256_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

### rtl/core/sha256_message_hasher_top.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher_top: byte-serial SHA-256 hasher
// Shifts bytes into a 64-byte block register, compresses with one round unit,
// pads on the final byte and streams the eight digest words.
// ----------------------------------------------------------------------------
//  channel  dir  transfer payload
//  in_      in   data_byte[7:0], byte_valid, last_byte
//  out_     out  digest_word[31:0], word_index[2:0], last_word
//
//  A byte that does not fill a block is shifted into the block register.
//  A full block passes through a load state, 64 rounds of the shared
//  round unit and an add state. A final item adds padding (pad bytes
//  shifted in one at a time) and one or two compressions, then eight
//  word transfers. Reset is synchronous; stalls on out_ready hold the word.
// ----------------------------------------------------------------------------
`default_nettype none
module sha256_message_hasher_top
  import sha256_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  sha256_in_if.sink       in_ch,
  sha256_out_if.source    out_ch
);

  typedef enum logic [2:0] {
    S_IDLE, S_PAD, S_LOAD, S_ROUND, S_ADD, S_OUT
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;
  logic [60:0] total_r, total_nxt;
  logic [5:0]  round_r, round_nxt;
  logic        final_r, final_nxt;   // block being compressed ends the message
  logic        padded_r, padded_nxt; // 0x80 already written
  logic [2:0]  oidx_r, oidx_nxt;
  word_t       h_r [8];
  word_t       v_r [8];
  word_t       w_r [16];

  logic        wr_en;
  logic [7:0]  wr_data;
  logic [63:0] bit_len;
  logic        in_xfer, out_xfer;

  // The length fits this block when the pad byte landed at or before slot 55
  logic len_block, len_done_r, len_done;
  logic len_here_r;

  assign in_xfer  = in_ch.valid && in_ch.ready;
  assign out_xfer = out_ch.valid && out_ch.ready;
  assign bit_len  = {total_r, 3'b000};

  assign in_ch.ready        = (state_r == S_IDLE);
  assign out_ch.valid       = (state_r == S_OUT);
  assign out_ch.digest_word = h_r[oidx_r];
  assign out_ch.word_index  = oidx_r;
  assign out_ch.last_word   = (oidx_r == 3'd7);

  // Sequence bytes, padding, rounds and output
  always_comb begin
    state_nxt  = state_r;
    fill_nxt   = fill_r;
    total_nxt  = total_r;
    round_nxt  = round_r;
    final_nxt  = final_r;
    padded_nxt = padded_r;
    oidx_nxt   = oidx_r;
    wr_en      = 1'b0;
    wr_data    = in_ch.data_byte;
    case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_ch.byte_valid) begin
            wr_en     = 1'b1;
            fill_nxt  = fill_r + 6'd1;
            total_nxt = total_r + 61'd1;
          end
          final_nxt  = in_ch.last_byte;
          padded_nxt = 1'b0;
          if (in_ch.byte_valid && fill_r == 6'd63) state_nxt = S_LOAD;
          else if (in_ch.last_byte) state_nxt = S_PAD;
        end
      end
      S_PAD: begin
        wr_en    = 1'b1;
        fill_nxt = fill_r + 6'd1;
        if (!padded_r) begin
          wr_data    = PAD_BYTE;
          padded_nxt = 1'b1;
        end else begin
          wr_data = 8'h00;
        end
        // Length bytes go into the last eight slots of the last block
        if (fill_r >= 6'd56 && padded_r && len_block) begin
          wr_data = bit_len[8'(63 - 8 * (fill_r - 6'd56)) -: 8];
        end
        if (fill_r == 6'd63) state_nxt = S_LOAD;
      end
      S_LOAD: begin
        round_nxt = 6'd0;
        state_nxt = S_ROUND;
      end
      S_ROUND: begin
        round_nxt = round_r + 6'd1;
        if (round_r == 6'd63) state_nxt = S_ADD;
      end
      S_ADD: begin
        fill_nxt = 6'd0;
        if (!final_r) state_nxt = S_IDLE;
        else if (!len_done) state_nxt = S_PAD;
        else begin
          oidx_nxt  = 3'd0;
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (out_xfer) begin
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == 3'd7) begin
            state_nxt = S_IDLE;
            total_nxt = '0;
            final_nxt = 1'b0;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign len_block = len_here_r || (!padded_r && fill_r <= 6'd55);
  assign len_done  = len_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_here_r <= 1'b0;
      len_done_r <= 1'b0;
    end else begin
      if (state_r == S_IDLE) begin
        len_here_r <= 1'b0;
        len_done_r <= 1'b0;
      end else if (state_r == S_PAD && !padded_r) begin
        len_here_r <= (fill_r <= 6'd55);
        len_done_r <= (fill_r <= 6'd55);
      end else if (state_r == S_ADD && final_r && !len_done_r) begin
        len_here_r <= 1'b1;
        len_done_r <= 1'b1;
      end
    end
  end

  // Hold control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fill_r   <= '0;
      total_r  <= '0;
      round_r  <= '0;
      final_r  <= 1'b0;
      padded_r <= 1'b0;
      oidx_r   <= '0;
    end else begin
      state_r  <= state_nxt;
      fill_r   <= fill_nxt;
      total_r  <= total_nxt;
      round_r  <= round_nxt;
      final_r  <= final_nxt;
      padded_r <= padded_nxt;
      oidx_r   <= oidx_nxt;
    end
  end

  // Shared round unit
  word_t wt, s_new, t1, t2;
  assign s_new = ssig1(w_r[14]) + w_r[9] + ssig0(w_r[1]) + w_r[0];
  assign wt    = (round_r < 6'd16) ? w_r[0] : s_new;
  assign t1 = v_r[7] + bsig1(v_r[4]) + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
              + ROUND_K[round_r] + wt;
  assign t2 = bsig0(v_r[0]) + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  // Advance block register, working variables, schedule window and chaining words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
    end else begin
      case (state_r)
        S_IDLE, S_PAD: begin
          // Shift the next block byte in; the first byte ends up in w_r[0][31:24]
          if (wr_en) begin
            for (int i = 0; i < 15; i++) w_r[i] <= {w_r[i][23:0], w_r[i+1][31:24]};
            w_r[15] <= {w_r[15][23:0], wr_data};
          end
        end
        S_LOAD: begin
          for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
        end
        S_ROUND: begin
          for (int i = 0; i < 15; i++) w_r[i] <= w_r[i+1];
          w_r[15] <= wt;
          v_r[0] <= t1 + t2;
          v_r[1] <= v_r[0];
          v_r[2] <= v_r[1];
          v_r[3] <= v_r[2];
          v_r[4] <= v_r[3] + t1;
          v_r[5] <= v_r[4];
          v_r[6] <= v_r[5];
          v_r[7] <= v_r[6];
        end
        S_ADD: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        end
        S_OUT: begin
          if (out_xfer && oidx_r == 3'd7)
            for (int i = 0; i < 8; i++) h_r[i] <= init_h(3'(i));
        end
        default: ;
      endcase
    end
  end

  // Checks
  a_no_in_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND) |-> !in_ch.ready) else $error("ready during rounds");
  a_round_to_add: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ROUND && round_r == 6'd63) |=> (state_r == S_ADD))
    else $error("round count slip");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> $stable(oidx_r)) else $error("index moved");

endmodule
`default_nettype wire
